// File: design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, constants and codes for the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int W         = 18;                   // element and result width
   localparam longint ONE   = longint'(1) << FRAC_BITS;
   localparam longint EPS   = (ONE + 500000) / 1000000;
   localparam longint QMAX  = (longint'(1) << (W - 1)) - 1;
   localparam longint QMIN  = -(longint'(1) << (W - 1));

   // signed width of one plus three elements
   localparam int SUMW = ((W > FRAC_BITS + 2) ? W : FRAC_BITS + 2) + 2;
   localparam int RADU = SUMW - 1;                   // non-negative radicand
   localparam int VW   = RADU + FRAC_BITS;           // radicand scaled by ONE
   localparam int RW   = (VW + 1) / 2;               // root width
   localparam int SW   = RW + 1;                     // S = 2 * root
   localparam int NW   = W + 1;                      // numerator, signed
   localparam int MW   = W + 1;                      // numerator magnitude
   localparam int DW   = MW + FRAC_BITS + 1;         // rounded dividend
   localparam int CW   = (DW > SW + W) ? DW : SW + W;

   localparam int SQ_LAT = RW + 1;
   localparam int DV_LAT = W + 1;

   typedef enum logic [1:0] {
      SEL_TRACE = 2'd0,
      SEL_COL0  = 2'd1,
      SEL_COL1  = 2'd2,
      SEL_COL2  = 2'd3
   } sel_type;

endpackage

// File: design/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts the rotation part of a matrix (Q2.16) to a quaternion (Q2.16).
// ----------------------------------------------------------------------------
// Fully pipelined: one matrix is taken every cycle unless the pipe holds; its
// Q2.16 result passes input and select registers, a bit-per-stage square
// root, three parallel bit-per-stage dividers and the output register. The
// whole pipe holds while a finished result is stalled; req_stall mirrors it.
module rotation_matrix_to_quaternion (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [rmq_pkg::W-1:0] req_a00,
   input  logic signed [rmq_pkg::W-1:0] req_a01,
   input  logic signed [rmq_pkg::W-1:0] req_a02,
   input  logic signed [rmq_pkg::W-1:0] req_a10,
   input  logic signed [rmq_pkg::W-1:0] req_a11,
   input  logic signed [rmq_pkg::W-1:0] req_a12,
   input  logic signed [rmq_pkg::W-1:0] req_a20,
   input  logic signed [rmq_pkg::W-1:0] req_a21,
   input  logic signed [rmq_pkg::W-1:0] req_a22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [rmq_pkg::W-1:0] rsp_qx,
   output logic signed [rmq_pkg::W-1:0] rsp_qy,
   output logic signed [rmq_pkg::W-1:0] rsp_qz,
   output logic signed [rmq_pkg::W-1:0] rsp_qw,
   output logic [1:0]                   rsp_case_taken,
   output logic                         rsp_degenerate
);

   localparam int W    = rmq_pkg::W;
   localparam int NW   = rmq_pkg::NW;
   localparam int SUMW = rmq_pkg::SUMW;
   localparam int RW   = rmq_pkg::RW;
   localparam int SQL  = rmq_pkg::SQ_LAT;
   localparam int DVL  = rmq_pkg::DV_LAT;
   localparam int VLEN = 2 + SQL + DVL;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // valid bits: stage A, stage B, sqrt stages, divider stages
   logic [VLEN-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[VLEN-2:0], req_valid};
   end

   // stage A: input register
   logic signed [W-1:0] a_ff [0:8];

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= req_a00; a_ff[1] <= req_a01; a_ff[2] <= req_a02;
         a_ff[3] <= req_a10; a_ff[4] <= req_a11; a_ff[5] <= req_a12;
         a_ff[6] <= req_a20; a_ff[7] <= req_a21; a_ff[8] <= req_a22;
      end
   end

   // stage B: case select, radicand, numerators
   logic signed [SUMW-1:0] e00, e11, e22, one_s, t_v, rad_v;
   logic signed [NW-1:0]   d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;
   rmq_pkg::sel_type       sel_v;
   logic signed [NW-1:0]   n_v [0:2];

   always_comb begin
      e00   = SUMW'(a_ff[0]);
      e11   = SUMW'(a_ff[4]);
      e22   = SUMW'(a_ff[8]);
      one_s = SUMW'(rmq_pkg::ONE);
      t_v   = one_s + e00 + e11 + e22;
      d21m12 = NW'(a_ff[7]) - NW'(a_ff[5]);
      d02m20 = NW'(a_ff[2]) - NW'(a_ff[6]);
      d10m01 = NW'(a_ff[3]) - NW'(a_ff[1]);
      s10p01 = NW'(a_ff[3]) + NW'(a_ff[1]);
      s02p20 = NW'(a_ff[2]) + NW'(a_ff[6]);
      s21p12 = NW'(a_ff[7]) + NW'(a_ff[5]);
      if (t_v > SUMW'(rmq_pkg::EPS)) begin
         sel_v = rmq_pkg::SEL_TRACE;
         rad_v = t_v;
         n_v[0] = d21m12; n_v[1] = d02m20; n_v[2] = d10m01;
      end else if (a_ff[0] > a_ff[4] && a_ff[0] > a_ff[8]) begin
         sel_v = rmq_pkg::SEL_COL0;
         rad_v = one_s + e00 - e11 - e22;
         n_v[0] = s10p01; n_v[1] = s02p20; n_v[2] = d21m12;
      end else if (a_ff[4] > a_ff[8]) begin
         sel_v = rmq_pkg::SEL_COL1;
         rad_v = one_s + e11 - e00 - e22;
         n_v[0] = s10p01; n_v[1] = s21p12; n_v[2] = d02m20;
      end else begin
         sel_v = rmq_pkg::SEL_COL2;
         rad_v = one_s + e22 - e00 - e11;
         n_v[0] = s02p20; n_v[1] = s21p12; n_v[2] = d10m01;
      end
   end

   logic [rmq_pkg::RADU-1:0] rad_ff;
   rmq_pkg::sel_type         sel_b_ff;
   logic signed [NW-1:0]     num_b_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff   <= rad_v[SUMW-1] ? '0 : rad_v[rmq_pkg::RADU-1:0];
         sel_b_ff <= sel_v;
         num_b_ff <= n_v;
      end
   end

   // square root, with numerators and select delayed alongside
   logic [RW-1:0] root;

   rmq_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   rmq_pkg::sel_type     sel_s_ff [0:SQL-1];
   logic signed [NW-1:0] num_s_ff [0:SQL-1][0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         sel_s_ff[0] <= sel_b_ff;
         num_s_ff[0] <= num_b_ff;
         for (int i = 1; i < SQL; i++) begin
            sel_s_ff[i] <= sel_s_ff[i-1];
            num_s_ff[i] <= num_s_ff[i-1];
         end
      end
   end

   // dividers, with root and select delayed alongside
   logic [rmq_pkg::SW-1:0] s_v;
   logic signed [W-1:0]    quo [0:2];
   assign s_v = {root, 1'b0};

   for (genvar j = 0; j < 3; j++) begin : g_div
      rmq_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num_s_ff[SQL-1][j]),
         .s     (s_v),
         .quo   (quo[j])
      );
   end

   rmq_pkg::sel_type sel_d_ff  [0:DVL-1];
   logic [RW-1:0]    root_d_ff [0:DVL-1];

   always_ff @(posedge clock) begin
      if (en) begin
         sel_d_ff[0]  <= sel_s_ff[SQL-1];
         root_d_ff[0] <= root;
         for (int i = 1; i < DVL; i++) begin
            sel_d_ff[i]  <= sel_d_ff[i-1];
            root_d_ff[i] <= root_d_ff[i-1];
         end
      end
   end

   // output stage
   logic [RW:0]         qtr_full;
   logic signed [W-1:0] qtr;
   logic signed [W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic [RW-1:0]       root_o;
   rmq_pkg::sel_type    sel_o;

   always_comb begin
      root_o   = root_d_ff[DVL-1];
      sel_o    = sel_d_ff[DVL-1];
      qtr_full = ({1'b0, root_o} + (RW + 1)'(1)) >> 1;
      if (qtr_full > (RW + 1)'(rmq_pkg::QMAX))
         qtr = W'(rmq_pkg::QMAX);
      else
         qtr = W'(qtr_full);
      case (sel_o)
         rmq_pkg::SEL_TRACE: begin
            qx_in = quo[0]; qy_in = quo[1]; qz_in = quo[2]; qw_in = qtr;
         end
         rmq_pkg::SEL_COL0: begin
            qx_in = qtr; qy_in = quo[0]; qz_in = quo[1]; qw_in = quo[2];
         end
         rmq_pkg::SEL_COL1: begin
            qx_in = quo[0]; qy_in = qtr; qz_in = quo[1]; qw_in = quo[2];
         end
         default: begin
            qx_in = quo[0]; qy_in = quo[1]; qz_in = qtr; qw_in = quo[2];
         end
      endcase
   end

   logic                rsp_valid_ff;
   logic signed [W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic [1:0]          case_ff;
   logic                degen_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (en)
         rsp_valid_ff <= vld_ff[VLEN-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         qz_ff    <= qz_in;
         qw_ff    <= qw_in;
         case_ff  <= sel_o;
         degen_ff <= root_o == '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_qx         = qx_ff;
   assign rsp_qy         = qy_ff;
   assign rsp_qz         = qz_ff;
   assign rsp_qw         = qw_ff;
   assign rsp_case_taken = case_ff;
   assign rsp_degenerate = degen_ff;

endmodule

// File: design/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage: root = floor(sqrt(
// rad * ONE)).
// ----------------------------------------------------------------------------
module rmq_sqrt (
   input  logic                     clock,
   input  logic                     en,
   input  logic [rmq_pkg::RADU-1:0] rad,
   output logic [rmq_pkg::RW-1:0]   root
);

   localparam int RW = rmq_pkg::RW;
   localparam int VV = 2 * RW;

   logic [RW+1:0] rem_ff [0:RW];
   logic [RW-1:0] r_ff   [0:RW];
   logic [VV-1:0] v_ff   [0:RW];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         r_ff[0]   <= '0;
         v_ff[0]   <= VV'({{(VV - rmq_pkg::RADU){1'b0}}, rad} << rmq_pkg::FRAC_BITS);
      end
   end

   for (genvar k = 1; k <= RW; k++) begin : g_stage
      logic [RW+3:0] raw;
      logic [RW+3:0] trial;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] r_in;

      always_comb begin
         raw   = {rem_ff[k-1], v_ff[k-1][VV-1 -: 2]};
         trial = {2'b00, r_ff[k-1], 2'b01};
         if (raw >= trial) begin
            rem_in = (RW + 2)'(raw - trial);
            r_in   = {r_ff[k-1][RW-2:0], 1'b1};
         end else begin
            rem_in = (RW + 2)'(raw);
            r_in   = {r_ff[k-1][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            r_ff[k]   <= r_in;
            v_ff[k]   <= v_ff[k-1] << 2;
         end
      end
   end

   assign root = r_ff[RW];

endmodule

// File: design/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage: num / S in fixed
// point, rounded half away from zero, saturated, zero S handled.
// ----------------------------------------------------------------------------
module rmq_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [rmq_pkg::NW-1:0] num,
   input  logic [rmq_pkg::SW-1:0]        s,
   output logic signed [rmq_pkg::W-1:0]  quo
);

   localparam int W  = rmq_pkg::W;
   localparam int CW = rmq_pkg::CW;

   logic [CW-1:0] rem_ff  [0:W];
   logic [W-1:0]  q_ff    [0:W];
   logic [CW-1:0] s_ff    [0:W];
   logic          ov_ff   [0:W];
   logic          zero_ff [0:W];
   logic          neg_ff  [0:W];
   logic          nz_ff   [0:W];

   logic [rmq_pkg::MW-1:0] mag;
   logic [CW-1:0]          dvd;
   logic [CW-1:0]          s_ext;

   always_comb begin
      mag   = num[rmq_pkg::NW-1] ? rmq_pkg::MW'(-num) : rmq_pkg::MW'(num);
      s_ext = CW'(s);
      dvd   = (CW'(mag) << rmq_pkg::FRAC_BITS) + (s_ext >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= dvd;
         q_ff[0]    <= '0;
         s_ff[0]    <= s_ext;
         ov_ff[0]   <= dvd >= (s_ext << W);
         zero_ff[0] <= s == '0;
         neg_ff[0]  <= num[rmq_pkg::NW-1];
         nz_ff[0]   <= num != '0;
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_stage
      logic [CW-1:0] sh;
      logic          ge;

      always_comb begin
         sh = s_ff[k-1] << (W - k);
         ge = rem_ff[k-1] >= sh;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? rem_ff[k-1] - sh : rem_ff[k-1];
            q_ff[k]    <= q_ff[k-1] | (W'(ge) << (W - k));
            s_ff[k]    <= s_ff[k-1];
            ov_ff[k]   <= ov_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            nz_ff[k]   <= nz_ff[k-1];
         end
      end
   end

   always_comb begin
      if (zero_ff[W]) begin
         if (!nz_ff[W])
            quo = '0;
         else
            quo = neg_ff[W] ? W'(rmq_pkg::QMIN) : W'(rmq_pkg::QMAX);
      end else if (neg_ff[W]) begin
         if (ov_ff[W] || ({1'b0, q_ff[W]} > (W + 1)'(-rmq_pkg::QMIN)))
            quo = W'(rmq_pkg::QMIN);
         else
            quo = W'(-q_ff[W]);
      end else begin
         if (ov_ff[W] || ({1'b0, q_ff[W]} > (W + 1)'(rmq_pkg::QMAX)))
            quo = W'(rmq_pkg::QMAX);
         else
            quo = q_ff[W];
      end
   end

endmodule

// File: bench/rotation_matrix_to_quaternion_check.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_check
// Watches both channels, predicts the quaternion of every accepted matrix
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [rmq_pkg::W-1:0] req_a00, req_a01, req_a02,
   input  logic signed [rmq_pkg::W-1:0] req_a10, req_a11, req_a12,
   input  logic signed [rmq_pkg::W-1:0] req_a20, req_a21, req_a22,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [rmq_pkg::W-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw,
   input  logic [1:0]                   rsp_case_taken,
   input  logic                         rsp_degenerate,
   output int                           fail_count,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = rmq_pkg::W;

   typedef struct packed {
      logic signed [W-1:0] qx, qy, qz, qw;
      rmq_pkg::sel_type    sel;
      logic                degen;
   } quat_type;

   quat_type quat_queue[$];

   assign pending = quat_queue.size();

   function automatic longint clamp(longint v);
      if (v > rmq_pkg::QMAX) return rmq_pkg::QMAX;
      if (v < rmq_pkg::QMIN) return rmq_pkg::QMIN;
      return v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // num / s, rounded half away from zero, saturated; zero s saturates by sign
   function automatic longint fix_div(longint num, longint s);
      longint mag, q;
      if (s == 0) return (num == 0) ? 0 : ((num < 0) ? rmq_pkg::QMIN : rmq_pkg::QMAX);
      mag = (num < 0) ? -num : num;
      q = ((mag << rmq_pkg::FRAC_BITS) + (s >> 1)) / s;
      if (num < 0) return (q > -rmq_pkg::QMIN) ? rmq_pkg::QMIN : -q;
      return (q > rmq_pkg::QMAX) ? rmq_pkg::QMAX : q;
   endfunction

   function automatic quat_type convert_matrix(longint m00, m01, m02, m10, m11,
                                               m12, m20, m21, m22);
      quat_type q;
      longint   t, rad, root, s, qtr;
      t = rmq_pkg::ONE + m00 + m11 + m22;
      if (t > rmq_pkg::EPS) begin
         q.sel = rmq_pkg::SEL_TRACE; rad = t;
      end else if (m00 > m11 && m00 > m22) begin
         q.sel = rmq_pkg::SEL_COL0; rad = rmq_pkg::ONE + m00 - m11 - m22;
      end else if (m11 > m22) begin
         q.sel = rmq_pkg::SEL_COL1; rad = rmq_pkg::ONE + m11 - m00 - m22;
      end else begin
         q.sel = rmq_pkg::SEL_COL2; rad = rmq_pkg::ONE + m22 - m00 - m11;
      end
      if (rad < 0) rad = 0;
      root = int_sqrt(rad << rmq_pkg::FRAC_BITS);
      s = root << 1;
      qtr = clamp((root + 1) >> 1);
      case (q.sel)
         rmq_pkg::SEL_TRACE: begin
            q.qx = W'(fix_div(m21 - m12, s)); q.qy = W'(fix_div(m02 - m20, s));
            q.qz = W'(fix_div(m10 - m01, s)); q.qw = W'(qtr);
         end
         rmq_pkg::SEL_COL0: begin
            q.qx = W'(qtr);                   q.qy = W'(fix_div(m10 + m01, s));
            q.qz = W'(fix_div(m02 + m20, s)); q.qw = W'(fix_div(m21 - m12, s));
         end
         rmq_pkg::SEL_COL1: begin
            q.qx = W'(fix_div(m10 + m01, s)); q.qy = W'(qtr);
            q.qz = W'(fix_div(m21 + m12, s)); q.qw = W'(fix_div(m02 - m20, s));
         end
         default: begin
            q.qx = W'(fix_div(m02 + m20, s)); q.qy = W'(fix_div(m21 + m12, s));
            q.qz = W'(qtr);                   q.qw = W'(fix_div(m10 - m01, s));
         end
      endcase
      q.degen = (s == 0);
      return q;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      quat_type e;
      if (!reset && req_valid && !req_stall)
         quat_queue.push_back(convert_matrix(req_a00, req_a01, req_a02, req_a10,
            req_a11, req_a12, req_a20, req_a21, req_a22));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quat_queue.size() == 0) begin
            report("unexpected transfer", 1, 0);
         end else begin
            e = quat_queue.pop_front();
            if (rsp_qx !== e.qx) report("qx", rsp_qx, e.qx);
            if (rsp_qy !== e.qy) report("qy", rsp_qy, e.qy);
            if (rsp_qz !== e.qz) report("qz", rsp_qz, e.qz);
            if (rsp_qw !== e.qw) report("qw", rsp_qw, e.qw);
            if (rsp_case_taken !== e.sel) report("case_taken", rsp_case_taken, e.sel);
            if (rsp_degenerate !== e.degen) report("degenerate", rsp_degenerate, e.degen);
         end
      end
   end

endmodule

// File: bench/rotation_matrix_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives directed and random matrices with random gaps and output stalls;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W         = rmq_pkg::W;
   localparam int N_RANDOM  = 2000;
   localparam int IDLE_MAX  = 2000;
   localparam longint FULL  = 65536;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [W-1:0] req_a00 = '0, req_a01 = '0, req_a02 = '0;
   logic signed [W-1:0] req_a10 = '0, req_a11 = '0, req_a12 = '0;
   logic signed [W-1:0] req_a20 = '0, req_a21 = '0, req_a22 = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [W-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic [1:0] rsp_case_taken;
   logic rsp_degenerate;
   int   fail_count, pending, idle_cycles;
   logic stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   rotation_matrix_to_quaternion dut (.*);

   rotation_matrix_to_quaternion_check checker_i (.*);

   // called at a falling edge; valid stays high across back-to-back transfers
   task automatic send(longint m[9]);
      int gap;
      gap = $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_a00 <= W'(m[0]); req_a01 <= W'(m[1]); req_a02 <= W'(m[2]);
      req_a10 <= W'(m[3]); req_a11 <= W'(m[4]); req_a12 <= W'(m[5]);
      req_a20 <= W'(m[6]); req_a21 <= W'(m[7]); req_a22 <= W'(m[8]);
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic longint rnd_elem();
      return longint'($signed(W'($urandom)));
   endfunction

   // a random rotation-like matrix: small perturbations of a signed permutation
   function automatic void near_rotation(output longint m[9]);
      int perm, k;
      for (k = 0; k < 9; k++) m[k] = longint'($urandom_range(0, 4000)) - 2000;
      perm = $urandom_range(0, 2);
      for (k = 0; k < 3; k++)
         m[k * 3 + (k + perm) % 3] += ($urandom_range(0, 1) ? FULL : -FULL)
            - ($urandom_range(0, 1) ? longint'($urandom_range(0, 30000)) : longint'(0));
   endfunction

   // response stall: random length per transfer
   initial begin
      int stall_len;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
         if (stall_len > 0) begin
            rsp_stall <= 1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 0;
         @(negedge clock);
         while (!(rsp_valid && !rsp_stall)) @(negedge clock);
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(50, 200)) @(negedge clock);
      end
   end

   initial begin
      longint m[9];
      int i, k;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: identity, extremes, each column, zero trace, diagonal ties
      m = '{FULL, 0, 0, 0, FULL, 0, 0, 0, FULL};                      send(m);
      m = '{FULL, 0, 0, 0, -FULL, 0, 0, 0, -FULL};                    send(m);
      m = '{-FULL, 0, 0, 0, FULL, 0, 0, 0, -FULL};                    send(m);
      m = '{-FULL, 0, 0, 0, -FULL, 0, 0, 0, FULL};                    send(m);
      m = '{-FULL, 5, 7, 9, -FULL, 3, 2, 1, -FULL};                   send(m);
      m = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072};
      send(m);
      m = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
      send(m);
      m = '{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
            -131072};                                                 send(m);
      m = '{-FULL, 100, 0, 0, -FULL, 0, 0, 0, -FULL + 1};             send(m);
      m = '{-FULL / 2, 1, -1, 1, -FULL / 2, 1, -1, 1, 0};             send(m);
      m = '{-21846, 0, 0, 0, -21845, 0, 0, 0, -21845};                send(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, -FULL};                           send(m);
      m = '{-FULL, 0, 0, 0, 0, 0, 0, 0, 0};                           send(m);
      m = '{0, 131071, -131072, -131072, 0, 131071, 131071, -131072, -FULL + 1};
      send(m);
      m = '{-40000, 0, 0, 0, -40000, 0, 0, 0, -40000};                send(m);
      for (i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: for (k = 0; k < 9; k++) m[k] = rnd_elem();
            3: begin
               for (k = 0; k < 9; k++) m[k] = rnd_elem();
               m[0] = -longint'($urandom_range(0, 131072));
               m[4] = -longint'($urandom_range(0, 131072));
               m[8] = -longint'($urandom_range(0, 131072));
            end
            default: near_rotation(m);
         endcase
         send(m);
      end
      req_valid <= 0;
      stim_done <= 1;
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (stim_done && pending == 0) begin
            repeat (100) @(posedge clock);
            if (fail_count == 0) $display("end of test: clean");
            else $display("end of test: mismatches");
            $finish;
         end else if (idle_cycles >= IDLE_MAX) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule

// File: rotation_matrix_to_quaternion.f
design/rmq_pkg.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
bench/rotation_matrix_to_quaternion_check.sv
bench/rotation_matrix_to_quaternion_test.sv
